>>> sv/rdh_pkg.sv
package rdh_pkg;

  localparam int unsigned HdrBytes     = 12;
  localparam int unsigned FuHdrAt      = 13;
  localparam logic [4:0]  FuAType      = 5'd28;
  localparam int unsigned CmdQDepth    = 2;
  localparam logic [2:0]  ScCodeLast   = 3'd3;
  localparam logic [2:0]  ScLastStep   = 3'd4;
  localparam logic [7:0]  ScCodeOne    = 8'h01;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_end;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       unit_done;
    logic       drop_partial;
    logic       run_last;
  } out_res_t;

  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_SC     = 2'd1,
    CMD_MARKER = 2'd2
  } cmd_kind_e;

  // One classified packet byte, expanded by the back end into its results.
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic       drop;
    logic       done;
  } cmd_t;

endpackage

>>> sv/rtp_h264_depacketizer_core.sv
// RTP H.264 depacketizer: takes RTP packet bytes one per request with a last-byte
// mark, drops the 12-byte RTP header and writes an Annex B byte stream, rebuilding
// FU-A fragments into whole NAL units. The front end classifies each byte
// combinationally and posts a command into a two-entry queue; the back end turns
// each command into its results through an output register, one result per cycle
// while the output is not held by out_ready_i. Most bytes give one result; the NAL
// header of a single NAL packet and the FU header of a start fragment each expand
// to five results (start code plus header), so those bytes hold the back end until
// all five are out, and the queue lets following bytes be taken meanwhile. Header
// bytes are accepted without producing results. There is no clearing pass after reset.
module rtp_h264_depacketizer_core #(
  parameter int unsigned MAX_PACKET_BYTES = 2048
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rdh_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rdh_pkg::out_res_t out_res_o
);
  import rdh_pkg::*;

  logic push;
  logic pop;
  logic q_empty;
  logic q_full;
  cmd_t push_cmd;
  cmd_t head_cmd;

  rdh_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_req_i  (in_req_i),
    .q_full_i  (q_full),
    .in_ready_o(in_ready_o),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  rdh_cmd_fifo u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  rdh_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .head_i     (head_cmd),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o)
  );

endmodule

>>> sv/rdh_front.sv
module rdh_front #(
  parameter int unsigned MAX_PACKET_BYTES = 2048
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  rdh_pkg::in_req_t in_req_i,
  input  logic            q_full_i,
  output logic            in_ready_o,
  output logic            push_o,
  output rdh_pkg::cmd_t   cmd_o
);
  import rdh_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_PACKET_BYTES);
  localparam logic [IdxW-1:0] IdxMax = IdxW'(MAX_PACKET_BYTES - 1);
  localparam logic [IdxW-1:0] IdxHdr = IdxW'(HdrBytes);
  localparam logic [IdxW-1:0] IdxFu  = IdxW'(FuHdrAt);

  logic [IdxW-1:0] byte_index_q, byte_index_d;
  logic            frag_mode_q, frag_mode_d;
  logic [2:0]      saved_f_nri_q, saved_f_nri_d;
  logic            frag_end_seen_q, frag_end_seen_d;
  logic            frag_open_q, frag_open_d;
  logic            accept;
  logic            has_cmd;
  cmd_t            cmd;
  logic [7:0]      b;
  logic            last;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_req_i.data_byte;
  assign last       = in_req_i.packet_end;

  always_comb begin
    byte_index_d    = byte_index_q;
    frag_mode_d     = frag_mode_q;
    saved_f_nri_d   = saved_f_nri_q;
    frag_end_seen_d = frag_end_seen_q;
    frag_open_d     = frag_open_q;
    has_cmd         = 1'b0;
    cmd             = '{kind: CMD_BYTE, data: b, drop: 1'b0, done: 1'b0};

    if (byte_index_q < IdxHdr) begin
      has_cmd = 1'b0;
    end else if (byte_index_q == IdxHdr) begin
      if (b[4:0] == FuAType) begin
        frag_mode_d     = 1'b1;
        saved_f_nri_d   = b[7:5];
        frag_end_seen_d = 1'b0;
      end else begin
        // A single NAL unit cuts off any fragmented unit still open.
        frag_mode_d = 1'b0;
        frag_open_d = 1'b0;
        has_cmd     = 1'b1;
        cmd         = '{kind: CMD_SC, data: b, drop: frag_open_q, done: last};
      end
    end else if (frag_mode_q && byte_index_q == IdxFu) begin
      frag_end_seen_d = b[6];
      if (b[7]) begin
        has_cmd = 1'b1;
        cmd     = '{kind: CMD_SC, data: {saved_f_nri_q, b[4:0]}, drop: 1'b0,
                    done: last && b[6]};
        frag_open_d = !(last && b[6]);
      end else if (last && b[6]) begin
        has_cmd     = 1'b1;
        cmd         = '{kind: CMD_MARKER, data: 8'h00, drop: 1'b0, done: 1'b1};
        frag_open_d = 1'b0;
      end
    end else begin
      has_cmd  = 1'b1;
      cmd.done = last && (frag_mode_q ? frag_end_seen_q : 1'b1);
      if (cmd.done) begin
        frag_open_d = 1'b0;
      end
    end

    if (last) begin
      byte_index_d = '0;
    end else if (byte_index_q < IdxMax) begin
      byte_index_d = byte_index_q + 1'b1;
    end
  end

  assign push_o = accept && has_cmd;
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q    <= '0;
      frag_mode_q     <= 1'b0;
      saved_f_nri_q   <= 3'd0;
      frag_end_seen_q <= 1'b0;
      frag_open_q     <= 1'b0;
    end else if (accept) begin
      byte_index_q    <= byte_index_d;
      frag_mode_q     <= frag_mode_d;
      saved_f_nri_q   <= saved_f_nri_d;
      frag_end_seen_q <= frag_end_seen_d;
      frag_open_q     <= frag_open_d;
    end
  end

endmodule

>>> sv/rdh_cmd_fifo.sv
module rdh_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rdh_pkg::cmd_t push_data_i,
  input  logic          pop_i,
  output rdh_pkg::cmd_t head_o,
  output logic          empty_o,
  output logic          full_o
);
  import rdh_pkg::*;

  localparam int unsigned PtrW = $clog2(CmdQDepth);
  localparam int unsigned CntW = $clog2(CmdQDepth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(CmdQDepth);

  cmd_t            mem_q [CmdQDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntFull);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(CmdQDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(CmdQDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("command queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("command queue read while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("command queue count out of range");
`endif

endmodule

>>> sv/rdh_back.sv
module rdh_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  rdh_pkg::cmd_t     head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rdh_pkg::out_res_t out_res_o
);
  import rdh_pkg::*;

  logic [2:0] step_q;
  logic       out_valid_q;
  out_res_t   out_q;
  out_res_t   res;
  logic       res_last;
  logic       load;

  assign load = !q_empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    res      = '{out_byte: 8'h00, byte_valid: 1'b1, unit_done: 1'b0,
                 drop_partial: 1'b0, run_last: 1'b0};
    res_last = 1'b1;
    case (head_i.kind)
      CMD_BYTE: begin
        res.out_byte  = head_i.data;
        res.unit_done = head_i.done;
        res.run_last  = 1'b1;
      end
      CMD_SC: begin
        // Start code 00 00 00 01, then the NAL header byte.
        res_last = (step_q == ScLastStep);
        if (step_q == '0) begin
          res.drop_partial = head_i.drop;
        end else if (step_q == ScCodeLast) begin
          res.out_byte = ScCodeOne;
        end else if (step_q == ScLastStep) begin
          res.out_byte  = head_i.data;
          res.unit_done = head_i.done;
          res.run_last  = 1'b1;
        end
      end
      CMD_MARKER: begin
        res.byte_valid = 1'b0;
        res.unit_done  = head_i.done;
        res.run_last   = 1'b1;
      end
      default: begin
        res.byte_valid = 1'b0;
        res.run_last   = 1'b1;
      end
    endcase
  end

  assign pop_o       = load && res_last;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        step_q      <= res_last ? 3'd0 : step_q + 3'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.byte_valid |-> out_q.out_byte == 8'h00 && out_q.run_last)
    else $error("marker-only result carries a byte");
  a_drop_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.drop_partial |-> out_q.byte_valid && out_q.out_byte == 8'h00
      && !out_q.run_last)
    else $error("drop flag outside the first start code byte");
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.unit_done |-> out_q.run_last)
    else $error("unit end on a result that is not the last of its byte");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != 3'd0 |-> !q_empty_i && head_i.kind == CMD_SC && step_q <= ScLastStep)
    else $error("start sequence step without a start command");
`endif

endmodule
